### rtl/core/sobel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types, constants and register codes of the streaming Sobel edge core.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W       = 8;
  localparam int SIZE_W      = 11;
  localparam int THR_W       = 8;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 8;
  localparam int SIZE_MIN    = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [THR_W-1:0]  HIGH_RST   = 8'd200;
  localparam logic [THR_W-1:0]  LOW_RST    = 8'd100;
  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_HIGH_THRESHOLD = 2'd2,
    REG_LOW_THRESHOLD  = 2'd3
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // window[row][col], row 0 oldest line, col 2 newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] sobel_win_t;

  typedef struct packed {
    logic emit;      // item produces results
    logic inner;     // centre is off the border
    logic last_col;
    logic last_row;
  } sobel_tag_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } sobel_line_t;

  typedef struct packed {
    pix_t value;
    logic last_col;
    logic last_row;
  } sobel_res_t;

endpackage

`default_nettype wire

### rtl/core/sobel_edge_threshold_stream_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_threshold_stream_core
// Streaming 3x3 Sobel edge detector with inverted, thresholded output.
// ----------------------------------------------------------------------------
// Takes one grey pixel per clock in raster order unless pixel_stall holds it
// off, and gives one result per clock unless result_stall holds it. Each
// pixel goes through a read-modify-write of a single line store that holds
// the upper and middle line of each column, then the 3x3 window, a gradient
// stage and the threshold stage, and lands in an 8-entry result queue that
// feeds the output register. The pixel at row r, column c (r, c >= 1) yields
// the centre at (r-1, c-1); the last pixel of a row also yields the right
// border centre as 0, so that row end gives two items, balanced by the first
// column of the next row that gives none. The bottom border row is never
// sent. pixel_stall is high in reset and otherwise rises only when the queue
// and the items in flight could overfill it, i.e. when the consumer stalls.
// The line store needs no clearing after reset: border centres never use it.
// Size and threshold registers are to be written over APB only while the
// core is idle; the core itself does not enforce this.
module sobel_edge_threshold_stream_core #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [sobel_pkg::ADDR_W-1:0]      paddr,
  input  wire [sobel_pkg::DATA_W-1:0]      pwdata,
  output logic [sobel_pkg::DATA_W-1:0]     prdata,
  output logic                             pready,
  input  wire                              pixel_valid,
  output logic                             pixel_stall,
  input  wire [sobel_pkg::PIX_W-1:0]       pixel,
  output logic                             result_valid,
  input  wire                              result_stall,
  output logic [sobel_pkg::PIX_W-1:0]      edge_value,
  output logic                             last_of_run,
  output logic                             end_of_frame
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WSZ_W = (COL_W + 1 > sobel_pkg::SIZE_W) ? COL_W + 1 : sobel_pkg::SIZE_W;
  localparam int HSZ_W = (ROW_W + 1 > sobel_pkg::SIZE_W) ? ROW_W + 1 : sobel_pkg::SIZE_W;
  localparam int CNT_W = $clog2(sobel_pkg::QUEUE_DEPTH + 1);
  localparam int CR_W  = CNT_W + 2;

  // configuration registers
  logic [sobel_pkg::SIZE_W-1:0] image_width, image_height;
  logic [sobel_pkg::THR_W-1:0]  high_threshold, low_threshold;
  sobel_pkg::reg_idx_t          reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = sobel_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= sobel_pkg::WIDTH_RST;
      image_height   <= sobel_pkg::HEIGHT_RST;
      high_threshold <= sobel_pkg::HIGH_RST;
      low_threshold  <= sobel_pkg::LOW_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sobel_pkg::REG_IMAGE_WIDTH:    image_width    <= pwdata[sobel_pkg::SIZE_W-1:0];
        sobel_pkg::REG_IMAGE_HEIGHT:   image_height   <= pwdata[sobel_pkg::SIZE_W-1:0];
        sobel_pkg::REG_HIGH_THRESHOLD: high_threshold <= pwdata[sobel_pkg::THR_W-1:0];
        sobel_pkg::REG_LOW_THRESHOLD:  low_threshold  <= pwdata[sobel_pkg::THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sobel_pkg::REG_IMAGE_WIDTH:    prdata = sobel_pkg::DATA_W'(image_width);
      sobel_pkg::REG_IMAGE_HEIGHT:   prdata = sobel_pkg::DATA_W'(image_height);
      sobel_pkg::REG_HIGH_THRESHOLD: prdata = sobel_pkg::DATA_W'(high_threshold);
      sobel_pkg::REG_LOW_THRESHOLD:  prdata = sobel_pkg::DATA_W'(low_threshold);
    endcase
  end

  // clamped last column and last row
  logic [WSZ_W-1:0] w_ext;
  logic [HSZ_W-1:0] h_ext;
  logic [COL_W-1:0] wlast;
  logic [ROW_W-1:0] hlast;

  always_comb begin
    w_ext = WSZ_W'(image_width);
    h_ext = HSZ_W'(image_height);
    priority if (w_ext < WSZ_W'(sobel_pkg::SIZE_MIN)) begin
      wlast = COL_W'(sobel_pkg::SIZE_MIN - 1);
    end else if (w_ext > WSZ_W'(MAX_WIDTH)) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(w_ext - WSZ_W'(1));
    end
    priority if (h_ext < HSZ_W'(sobel_pkg::SIZE_MIN)) begin
      hlast = ROW_W'(sobel_pkg::SIZE_MIN - 1);
    end else if (h_ext > HSZ_W'(MAX_HEIGHT)) begin
      hlast = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast = ROW_W'(h_ext - HSZ_W'(1));
    end
  end

  // raster position
  logic [COL_W-1:0]      col, col_next;
  logic [ROW_W-1:0]      row, row_next;
  logic                  accept;
  sobel_pkg::sobel_tag_t tag;

  assign accept = pixel_valid & ~pixel_stall;

  always_comb begin
    tag.last_col = col >= wlast;
    tag.last_row = row >= hlast;
    tag.emit     = (row != '0) && (col != '0);
    tag.inner    = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    if (tag.last_col) begin
      col_next = '0;
      row_next = tag.last_row ? '0 : row + ROW_W'(1);
    end else begin
      col_next = col + COL_W'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // datapath
  logic                  rd_busy, win_valid, grad_busy, res_valid;
  sobel_pkg::sobel_win_t win;
  sobel_pkg::sobel_tag_t win_tag;
  sobel_pkg::sobel_res_t res;
  logic [CNT_W-1:0]      q_count;

  sobel_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (pixel),
    .col       (col),
    .tag       (tag),
    .rd_busy   (rd_busy),
    .win_valid (win_valid),
    .win       (win),
    .win_tag   (win_tag)
  );

  sobel_grad u_grad (
    .clk            (clk),
    .rst            (rst),
    .win_valid      (win_valid),
    .win            (win),
    .win_tag        (win_tag),
    .high_threshold (high_threshold),
    .low_threshold  (low_threshold),
    .grad_busy      (grad_busy),
    .res_valid      (res_valid),
    .res            (res)
  );

  sobel_out_queue #(
    .DEPTH (sobel_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_data    (res),
    .count        (q_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .edge_value   (edge_value),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

  // hold off input when queued plus in-flight items could fill the queue
  assign pixel_stall = rst |
    ((CR_W'(q_count) + CR_W'(rd_busy) + CR_W'(win_valid) + CR_W'(grad_busy))
      >= CR_W'(sobel_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

### rtl/core/sobel_line_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_line_mem
// Combined two-line store with read-modify-write per pixel, and the 3x3 window.
// ----------------------------------------------------------------------------
module sobel_line_mem #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              accept,
  input  wire sobel_pkg::pix_t             pixel,
  input  wire [$clog2(MAX_WIDTH)-1:0]      col,
  input  wire sobel_pkg::sobel_tag_t       tag,
  output logic                             rd_busy,
  output logic                             win_valid,
  output sobel_pkg::sobel_win_t            win,
  output sobel_pkg::sobel_tag_t            win_tag
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  sobel_pkg::sobel_line_t mem [MAX_WIDTH];
  sobel_pkg::sobel_line_t rd_data;

  logic                  rd_valid;
  sobel_pkg::pix_t       rd_pixel;
  logic [COL_W-1:0]      rd_col;
  sobel_pkg::sobel_tag_t rd_tag;

  // read at accept, write back in the next cycle; consecutive items never
  // share a column, so the write never meets a read of the same entry
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[col];
    end
    if (rd_valid) begin
      mem[rd_col] <= '{upper: rd_data.middle, middle: rd_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_pixel <= pixel;
      rd_col   <= col;
      rd_tag   <= tag;
    end
    if (rd_valid) begin
      win_tag <= rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      win_valid <= 1'b0;
      win       <= '0;
    end else begin
      rd_valid  <= accept;
      win_valid <= rd_valid;
      if (rd_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= rd_data.upper;
        win[1][2] <= rd_data.middle;
        win[2][2] <= rd_pixel;
      end
    end
  end

  assign rd_busy = rd_valid;

endmodule

`default_nettype wire

### rtl/core/sobel_grad.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_grad
// Sobel gradients of the window, magnitude, inversion and thresholding.
// ----------------------------------------------------------------------------
module sobel_grad (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              win_valid,
  input  wire sobel_pkg::sobel_win_t       win,
  input  wire sobel_pkg::sobel_tag_t       win_tag,
  input  wire [sobel_pkg::THR_W-1:0]       high_threshold,
  input  wire [sobel_pkg::THR_W-1:0]       low_threshold,
  output logic                             grad_busy,
  output logic                             res_valid,
  output sobel_pkg::sobel_res_t            res
);

  logic [9:0]            gx_pos, gx_neg, gy_pos, gy_neg;
  logic                  gv;
  logic signed [10:0]    gx, gy;
  sobel_pkg::sobel_tag_t gtag;

  logic [9:0]            ax, ay;
  logic [10:0]           mag;
  sobel_pkg::pix_t       inv;
  sobel_pkg::pix_t       thr;

  always_comb begin
    gx_pos = 10'(win[0][2]) + 10'({win[1][2], 1'b0}) + 10'(win[2][2]);
    gx_neg = 10'(win[0][0]) + 10'({win[1][0], 1'b0}) + 10'(win[2][0]);
    gy_pos = 10'(win[2][0]) + 10'({win[2][1], 1'b0}) + 10'(win[2][2]);
    gy_neg = 10'(win[0][0]) + 10'({win[0][1], 1'b0}) + 10'(win[0][2]);
  end

  always_ff @(posedge clk) begin
    if (win_valid) begin
      gx   <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy   <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      gtag <= win_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else begin
      gv <= win_valid;
    end
  end

  always_comb begin
    ax  = gx[10] ? 10'(-gx) : 10'(gx);
    ay  = gy[10] ? 10'(-gy) : 10'(gy);
    mag = 11'(ax) + 11'(ay);
    inv = sobel_pkg::PIX_MAX - mag[7:0];
    // high test wins when the thresholds cross
    priority if (inv > high_threshold) begin
      thr = sobel_pkg::PIX_MAX;
    end else if (inv < low_threshold) begin
      thr = '0;
    end else begin
      thr = inv;
    end
  end

  assign grad_busy    = gv;
  assign res_valid    = gv & gtag.emit;
  assign res.value    = gtag.inner ? thr : '0;
  assign res.last_col = gtag.last_col;
  assign res.last_row = gtag.last_row;

endmodule

`default_nettype wire

### rtl/core/sobel_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_out_queue
// Result queue and output register; an entry at the last column is sent as
// the centre item followed by the right border item.
// ----------------------------------------------------------------------------
module sobel_out_queue #(
  parameter int DEPTH = sobel_pkg::QUEUE_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              push,
  input  wire sobel_pkg::sobel_res_t       push_data,
  output logic [$clog2(DEPTH+1)-1:0]       count,
  output logic                             result_valid,
  input  wire                              result_stall,
  output sobel_pkg::pix_t                  edge_value,
  output logic                             last_of_run,
  output logic                             end_of_frame
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  sobel_pkg::sobel_res_t q [DEPTH];
  logic [PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [PTR_W-1:0]      wr_ptr_next, rd_ptr_next;

  logic                  ov;
  logic                  ophase;   // second item of a last-column entry
  sobel_pkg::sobel_res_t ores;

  logic take, done, load;

  assign take = ov & ~result_stall;
  assign done = take & (ophase | ~ores.last_col);
  assign load = (~ov | done) & (count != '0);

  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
    if (load) begin
      ores <= q[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov     <= 1'b0;
      ophase <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (load) begin
        ov     <= 1'b1;
        ophase <= 1'b0;
        rd_ptr <= rd_ptr_next;
      end else if (done) begin
        ov <= 1'b0;
      end else if (take) begin
        ophase <= 1'b1;
      end
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      unique case ({push, load})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign result_valid = ov;
  assign edge_value   = ophase ? '0 : ores.value;
  assign last_of_run  = ophase | ~ores.last_col;
  assign end_of_frame = ophase & ores.last_row;

endmodule

`default_nettype wire

### rtl/core/sobel_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_checker
// Port-level checks of the Sobel edge core, bound to its top level.
// ----------------------------------------------------------------------------
module sobel_checker (
  input wire       clk,
  input wire       rst,
  input wire       pixel_stall,
  input wire       result_valid,
  input wire       result_stall,
  input wire [7:0] edge_value,
  input wire       last_of_run,
  input wire       end_of_frame
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable({edge_value, last_of_run, end_of_frame}))
    else $error("stalled result item changed");

  // frame end is the right border item of the last row
  a_eof: assert property (@(posedge clk)
    result_valid && end_of_frame |-> last_of_run && edge_value == 8'd0)
    else $error("end_of_frame on a non-border item");

  // the border item follows its centre at once
  a_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last_of_run |=>
      result_valid && last_of_run && edge_value == 8'd0)
    else $error("right border item missing after centre item");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result item right after reset");

  a_rst_ready: assert property (@(posedge clk)
    $fell(rst) |-> !pixel_stall)
    else $error("input held off right after reset");

endmodule

bind sobel_edge_threshold_stream_core sobel_checker u_sobel_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .edge_value   (edge_value),
  .last_of_run  (last_of_run),
  .end_of_frame (end_of_frame)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming Sobel edge core. Pixels are driven
// from a queue with random gaps and results are taken under random stall.
// A line-store model of the 3x3 window predicts every result. Each result is
// compared with the oldest prediction. Frame sizes and thresholds are set
// over APB between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int          MAX_W       = sobel_pkg::MAX_WIDTH_DEF;
  localparam int          MAX_H       = sobel_pkg::MAX_HEIGHT_DEF;
  localparam int          SETTLE      = 24;
  localparam int          LONG_HOLD   = 300;
  localparam int unsigned RANDOM_GOAL = 540;
  localparam longint      TIMEOUT_NS  = 64'd20_000_000;

  typedef enum int unsigned {
    STYLE_NOISE, STYLE_BINARY, STYLE_RAMP, STYLE_FLAT
  } pix_style_t;

  typedef struct packed {
    sobel_pkg::pix_t value;
    logic            last_of_run;
    logic            end_of_frame;
  } edge_rec_t;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [sobel_pkg::ADDR_W-1:0] paddr        = '0;
  logic [sobel_pkg::DATA_W-1:0] pwdata       = '0;
  logic [sobel_pkg::DATA_W-1:0] prdata;
  logic                         pready;
  logic                         pixel_valid  = 1'b0;
  logic                         pixel_stall;
  sobel_pkg::pix_t              pixel        = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  sobel_pkg::pix_t              edge_value;
  logic                         last_of_run;
  logic                         end_of_frame;

  sobel_edge_threshold_stream_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .edge_value   (edge_value),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // line stores, window and position of the edge model
  sobel_pkg::pix_t              upper_line [MAX_W];
  sobel_pkg::pix_t              middle_line [MAX_W];
  sobel_pkg::pix_t              win_px [3][3];
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;
  logic [sobel_pkg::SIZE_W-1:0] cfg_w   = sobel_pkg::WIDTH_RST;
  logic [sobel_pkg::SIZE_W-1:0] cfg_h   = sobel_pkg::HEIGHT_RST;
  logic [sobel_pkg::THR_W-1:0]  cfg_hi  = sobel_pkg::HIGH_RST;
  logic [sobel_pkg::THR_W-1:0]  cfg_lo  = sobel_pkg::LOW_RST;

  sobel_pkg::pix_t pixel_q [$];
  edge_rec_t       edge_q [$];
  int unsigned     fail_count   = 0;
  int unsigned     pixels_taken = 0;
  int unsigned     ramp_idx     = 0;
  bit              pixel_taken  = 1'b0;
  bit              calm         = 1'b0;
  bit              hold_armed   = 1'b0;
  bit              long_hold    = 1'b0;
  int unsigned     hold_at      = 0;
  int unsigned     send_pct     = 10;
  int unsigned     stall_pct    = 10;
  int unsigned     send_gap     = 0;
  int unsigned     stall_left   = 0;

  function automatic int unsigned eff_size(logic [sobel_pkg::SIZE_W-1:0] v,
                                           int unsigned maxv);
    if (v < sobel_pkg::SIZE_MIN) return sobel_pkg::SIZE_MIN;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int wp(int r, int c);
    return int'(win_px[r][c]);
  endfunction

  function automatic sobel_pkg::pix_t sobel_value();
    int              gx;
    int              gy;
    int              mag;
    sobel_pkg::pix_t inv;
    gx = (wp(0, 2) + 2 * wp(1, 2) + wp(2, 2)) - (wp(0, 0) + 2 * wp(1, 0) + wp(2, 0));
    gy = (wp(2, 0) + 2 * wp(2, 1) + wp(2, 2)) - (wp(0, 0) + 2 * wp(0, 1) + wp(0, 2));
    mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    inv = sobel_pkg::PIX_MAX - sobel_pkg::pix_t'(mag);
    // high test wins when the thresholds cross
    if (inv > cfg_hi) return sobel_pkg::PIX_MAX;
    if (inv < cfg_lo) return '0;
    return inv;
  endfunction

  task automatic predict_pixel(sobel_pkg::pix_t px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    int unsigned     r;
    sobel_pkg::pix_t top;
    sobel_pkg::pix_t mid;
    bit              lc;
    bit              lr;
    edge_rec_t       rec;
    w   = eff_size(cfg_w, MAX_W);
    h   = eff_size(cfg_h, MAX_H);
    c   = col_pos % MAX_W;
    r   = row_pos;
    top = upper_line[c];
    mid = middle_line[c];
    lc  = (c >= w - 1);
    lr  = (r >= h - 1);
    upper_line[c]  = mid;
    middle_line[c] = px;
    for (int i = 0; i < 3; i++) begin
      win_px[i][0] = win_px[i][1];
      win_px[i][1] = win_px[i][2];
    end
    win_px[0][2] = top;
    win_px[1][2] = mid;
    win_px[2][2] = px;
    if (r >= 1 && c >= 1) begin
      rec.value        = (r >= 2 && c >= 2) ? sobel_value() : '0;
      rec.last_of_run  = !lc;
      rec.end_of_frame = 1'b0;
      edge_q.push_back(rec);
      if (lc) begin
        // right border centre closes the row
        rec.value        = '0;
        rec.last_of_run  = 1'b1;
        rec.end_of_frame = lr;
        edge_q.push_back(rec);
      end
    end
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : (r + 1) & 10'h3FF;
    end else begin
      col_pos = (c + 1) & 10'h3FF;
    end
  endtask

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned rows_left;
    int unsigned cols_left;
    w = eff_size(cfg_w, MAX_W);
    h = eff_size(cfg_h, MAX_H);
    rows_left = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
    cols_left = (col_pos >= w - 1) ? 1 : w - col_pos;
    return rows_left * w + cols_left;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // result check first, then the model step for a pixel taken at this edge
  always @(posedge clk) begin : monitor
    edge_rec_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (edge_q.size() == 0) begin
          report_mismatch("result with none expected", edge_value, -1);
        end else begin
          want = edge_q.pop_front();
          if (edge_value !== want.value)
            report_mismatch("edge_value", edge_value, want.value);
          if (last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", last_of_run, want.last_of_run);
          if (end_of_frame !== want.end_of_frame)
            report_mismatch("end_of_frame", end_of_frame, want.end_of_frame);
        end
      end
      if (pixel_valid && !pixel_stall) begin
        predict_pixel(pixel);
        pixels_taken++;
        pixel_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin : pixel_driver
    if (!rst && (!pixel_valid || pixel_taken)) begin
      pixel_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        pixel_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pixel       <= pixel_q.pop_front();
        pixel_valid <= 1'b1;
        if (!calm && $urandom_range(99, 0) < send_pct)
          send_gap = $urandom_range(8, 1);
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_receiver
    if (!rst) begin
      if (long_hold) begin
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!calm && $urandom_range(99, 0) < stall_pct) begin
        stall_left = $urandom_range(7, 0);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering pixels
  initial begin : hold_off
    while (!(hold_armed && pixels_taken >= hold_at)) @(negedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(sobel_pkg::reg_idx_t idx, logic [sobel_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      sobel_pkg::REG_IMAGE_WIDTH:    cfg_w  = value[sobel_pkg::SIZE_W-1:0];
      sobel_pkg::REG_IMAGE_HEIGHT:   cfg_h  = value[sobel_pkg::SIZE_W-1:0];
      sobel_pkg::REG_HIGH_THRESHOLD: cfg_hi = value[sobel_pkg::THR_W-1:0];
      sobel_pkg::REG_LOW_THRESHOLD:  cfg_lo = value[sobel_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic sobel_pkg::pix_t make_pixel(pix_style_t style);
    ramp_idx++;
    case (style)
      STYLE_BINARY: return $urandom_range(1, 0) ? sobel_pkg::PIX_MAX : sobel_pkg::pix_t'(0);
      STYLE_RAMP:   return sobel_pkg::pix_t'(ramp_idx * 5 + $urandom_range(3, 0));
      STYLE_FLAT:   return sobel_pkg::pix_t'(8'd120 + $urandom_range(15, 0));
      default:      return sobel_pkg::pix_t'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic push_pixels(int unsigned n, pix_style_t style);
    for (int unsigned i = 0; i < n; i++) pixel_q.push_back(make_pixel(style));
  endtask

  // sender stays off until every expected result is out, then the pipe settles
  task automatic drain();
    while (pixel_q.size() != 0 || pixel_valid || edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_items;
    int unsigned n;
    int unsigned w_pick;
    int unsigned h_pick;
    pix_style_t  style;
    random_items = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame from out-of-range sizes, thresholds wide open
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd1);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd0);
    write_reg(sobel_pkg::REG_HIGH_THRESHOLD, 32'd255);
    write_reg(sobel_pkg::REG_LOW_THRESHOLD, 32'd0);
    pixel_q = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    drain();

    // low threshold above high, junk above the width field
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'hFFFF_F804);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd4);
    write_reg(sobel_pkg::REG_HIGH_THRESHOLD, 32'd10);
    write_reg(sobel_pkg::REG_LOW_THRESHOLD, 32'd250);
    pixel_q = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
                8'd255, 8'd255, 8'd0, 8'd0, 8'd1, 8'd128, 8'd254, 8'd127};
    drain();

    // size shrunk inside a frame: width first, then height
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd10);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd8);
    write_reg(sobel_pkg::REG_HIGH_THRESHOLD, 32'd200);
    write_reg(sobel_pkg::REG_LOW_THRESHOLD, 32'd100);
    push_pixels(36, STYLE_NOISE);
    drain();
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd4);
    push_pixels(pixels_to_frame_end(), STYLE_RAMP);
    drain();
    push_pixels(21, STYLE_BINARY);
    drain();
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd3);
    push_pixels(pixels_to_frame_end(), STYLE_NOISE);
    drain();

    // widest row, width clamped from above, receiver held off in the second
    // row; the frame is then closed at the narrowest width
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd2000);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd3);
    hold_at    = pixels_taken + 1030;
    hold_armed = 1'b1;
    push_pixels(1084, STYLE_NOISE);
    drain();
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd3);
    push_pixels(pixels_to_frame_end(), STYLE_NOISE);
    drain();

    // height clamped from the top of the field, then cut short
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd3);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd2047);
    push_pixels(15, STYLE_RAMP);
    drain();
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd3);
    push_pixels(pixels_to_frame_end(), STYLE_RAMP);
    drain();

    while (random_items < RANDOM_GOAL) begin
      case ($urandom_range(19, 0))
        0, 1:    w_pick = $urandom_range(2, 0);
        2:       w_pick = $urandom_range(40, 25);
        default: w_pick = $urandom_range(24, 3);
      endcase
      h_pick = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 3);
      write_reg(sobel_pkg::REG_IMAGE_WIDTH, w_pick);
      write_reg(sobel_pkg::REG_IMAGE_HEIGHT, h_pick);
      write_reg(sobel_pkg::REG_HIGH_THRESHOLD, $urandom());
      write_reg(sobel_pkg::REG_LOW_THRESHOLD, $urandom());
      send_pct  = pick_pct();
      stall_pct = pick_pct();
      style     = pix_style_t'($urandom_range(3, 0));
      if ($urandom_range(3, 0) == 0) begin
        n = $urandom_range(pixels_to_frame_end() - 1, 1);
        push_pixels(n, style);
        random_items += n;
        drain();
        // only shrink the width mid-frame so no unwritten store entry is read
        if ($urandom_range(1, 0))
          write_reg(sobel_pkg::REG_IMAGE_HEIGHT, $urandom_range(10, 0));
        else
          write_reg(sobel_pkg::REG_IMAGE_WIDTH, $urandom_range(eff_size(cfg_w, MAX_W), 0));
      end
      n = pixels_to_frame_end() + $urandom_range(1, 0) *
          eff_size(cfg_w, MAX_W) * eff_size(cfg_h, MAX_H);
      push_pixels(n, style);
      random_items += n;
      drain();
    end

    // closing stretch with no idling on either side
    calm = 1'b1;
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 32'd17);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 32'd6);
    write_reg(sobel_pkg::REG_HIGH_THRESHOLD, 32'd180);
    write_reg(sobel_pkg::REG_LOW_THRESHOLD, 32'd60);
    push_pixels(pixels_to_frame_end(), STYLE_NOISE);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sobel_pkg.sv
rtl/core/sobel_line_mem.sv
rtl/core/sobel_grad.sv
rtl/core/sobel_out_queue.sv
rtl/core/sobel_edge_threshold_stream_core.sv
rtl/core/sobel_checker.sv
bench/tb.sv
